// ===== rtl/core/json_string_unescape_utf8_defines.svh =====
// assertion macros shared by the json string unescape core
// no dependencies; included inside module bodies
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// same-cycle implication, disabled during reset
`define JSU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/jsu_pkg.sv =====
// shared types and codes for the json string unescape core
// no dependencies
package jsu_pkg;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_CTRL   = 3'd1;
   localparam logic [2:0] ERR_ESCAPE = 3'd2;
   localparam logic [2:0] ERR_HEX    = 3'd3;
   localparam logic [2:0] ERR_EARLY  = 3'd4;

   // all results caused by one input transaction
   typedef struct packed {
      logic [3:0][7:0] bytes;   // decoded bytes, first in [0]
      logic [2:0]      nbytes;  // number of valid bytes, 0..4
      logic            status;  // a status result follows the bytes
      logic            done;    // status marks the closing quote
      logic [2:0]      err;     // status error code
   } bundle_type;

endpackage

// ===== rtl/core/jsu_front.sv =====
// front end: accepts raw string bytes, runs the escape state machine and
// builds one bundle of results per transaction; uses jsu_pkg
module jsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               q_full,
   output logic               q_push,
   output jsu_pkg::bundle_type q_data
);
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      PH_TEXT, PH_ESC, PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4
   } phase_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      n;
   } enc_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_F = 8'h66;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_R = 8'h72;
   localparam logic [7:0] CH_T = 8'h74;
   localparam logic [7:0] CH_U = 8'h75;

   // utf-8 encoding of a 16-bit unit, 1 to 3 bytes
   function automatic enc_type encode_unit(input logic [15:0] u);
      enc_type e;
      e = '0;
      if (u < 16'h0080) begin
         e.bytes[0] = u[7:0];
         e.n = 2'd1;
      end else if (u < 16'h0800) begin
         e.bytes[0] = {3'b110, u[10:6]};
         e.bytes[1] = {2'b10, u[5:0]};
         e.n = 2'd2;
      end else begin
         e.bytes[0] = {4'b1110, u[15:12]};
         e.bytes[1] = {2'b10, u[11:6]};
         e.bytes[2] = {2'b10, u[5:0]};
         e.n = 2'd3;
      end
      return e;
   endfunction

   // {valid, value} of a hex digit
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [15:0] pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;

   logic        accept;
   enc_type     fl;
   logic [4:0]  hv;
   logic [15:0] acc_next;
   logic [20:0] scalar;
   logic [7:0]  esc_byte;
   logic        esc_ok;
   bundle_type  bnd;

   assign req_tready = !q_full;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      esc_ok = 1'b1;
      esc_byte = req_tdata;
      unique case (req_tdata) inside
         CH_B: esc_byte = 8'h08;
         CH_F: esc_byte = 8'h0C;
         CH_N: esc_byte = 8'h0A;
         CH_R: esc_byte = 8'h0D;
         CH_T: esc_byte = 8'h09;
         CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = req_tdata;
         default: esc_ok = 1'b0;
      endcase
   end

   always_comb begin
      fl = pend_valid_ff ? encode_unit(pend_ff) : '0;
      hv = hex_val(req_tdata);
      acc_next = {acc_ff[11:0], hv[3:0]};
      scalar = 21'({pend_ff[9:0], acc_next[9:0]}) + 21'h10000;

      phase_in = phase_ff;
      acc_in = acc_ff;
      pend_in = pend_ff;
      pend_valid_in = pend_valid_ff;

      // pending unit is flushed first in most arms
      bnd = '0;
      bnd.bytes[0] = fl.bytes[0];
      bnd.bytes[1] = fl.bytes[1];
      bnd.bytes[2] = fl.bytes[2];
      bnd.nbytes = {1'b0, fl.n};

      if (req_tlast) begin
         bnd = '0;
         bnd.status = 1'b1;
         bnd.err = ERR_EARLY;
         phase_in = PH_TEXT;
         acc_in = '0;
         pend_in = '0;
         pend_valid_in = 1'b0;
      end else begin
         unique case (phase_ff) inside
            PH_TEXT: begin
               if (req_tdata == CH_QUOTE) begin
                  bnd.status = 1'b1;
                  bnd.done = 1'b1;
                  acc_in = '0;
                  pend_in = '0;
                  pend_valid_in = 1'b0;
               end else if (req_tdata < 8'h20) begin
                  bnd = '0;
                  bnd.status = 1'b1;
                  bnd.err = ERR_CTRL;
                  acc_in = '0;
                  pend_in = '0;
                  pend_valid_in = 1'b0;
               end else if (req_tdata == CH_BSLASH) begin
                  bnd = '0;
                  phase_in = PH_ESC;
               end else begin
                  bnd.bytes[fl.n] = req_tdata;
                  bnd.nbytes = {1'b0, fl.n} + 3'd1;
                  pend_in = '0;
                  pend_valid_in = 1'b0;
               end
            end
            PH_ESC: begin
               if (req_tdata == CH_U) begin
                  bnd = '0;
                  phase_in = PH_HEX1;
                  acc_in = '0;
               end else if (!esc_ok) begin
                  bnd = '0;
                  bnd.status = 1'b1;
                  bnd.err = ERR_ESCAPE;
                  phase_in = PH_TEXT;
                  acc_in = '0;
                  pend_in = '0;
                  pend_valid_in = 1'b0;
               end else begin
                  bnd.bytes[fl.n] = esc_byte;
                  bnd.nbytes = {1'b0, fl.n} + 3'd1;
                  phase_in = PH_TEXT;
                  pend_in = '0;
                  pend_valid_in = 1'b0;
               end
            end
            PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
               if (!hv[4]) begin
                  bnd = '0;
                  bnd.status = 1'b1;
                  bnd.err = ERR_HEX;
                  phase_in = PH_TEXT;
                  acc_in = '0;
                  pend_in = '0;
                  pend_valid_in = 1'b0;
               end else if (phase_ff != PH_HEX4) begin
                  bnd = '0;
                  phase_in = phase_type'(phase_ff + 3'd1);
                  acc_in = acc_next;
               end else begin
                  phase_in = PH_TEXT;
                  acc_in = '0;
                  // high surrogate pending and low surrogate now: join them
                  if (pend_valid_ff && pend_ff[15:10] == 6'b110110
                      && acc_next[15:10] == 6'b110111) begin
                     bnd = '0;
                     bnd.bytes[0] = {5'b11110, scalar[20:18]};
                     bnd.bytes[1] = {2'b10, scalar[17:12]};
                     bnd.bytes[2] = {2'b10, scalar[11:6]};
                     bnd.bytes[3] = {2'b10, scalar[5:0]};
                     bnd.nbytes = 3'd4;
                     pend_in = '0;
                     pend_valid_in = 1'b0;
                  end else begin
                     pend_in = acc_next;
                     pend_valid_in = 1'b1;
                  end
               end
            end
            default: begin
               bnd = '0;
               phase_in = PH_TEXT;
            end
         endcase
      end
   end

   assign q_push = accept && (bnd.nbytes != 3'd0 || bnd.status);
   assign q_data = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TEXT;
         acc_ff <= '0;
         pend_ff <= '0;
         pend_valid_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         pend_ff <= pend_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

endmodule

// ===== rtl/core/jsu_fifo.sv =====
// short queue of result bundles between front and back end
// uses jsu_pkg and the assertion macro header
module jsu_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsu_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output jsu_pkg::bundle_type head,
   output logic                empty
);
   import jsu_pkg::*;
   `include "json_string_unescape_utf8_defines.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type      mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in;
   logic [AW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   `JSU_ASSERT_IMPLY(a_no_push_full, clock, reset, full, !push, "push into full queue")
   `JSU_ASSERT_IMPLY(a_no_pop_empty, clock, reset, empty, !pop, "pop from empty queue")
   `JSU_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + CW'(1), "queue count did not grow")
   `JSU_ASSERT_NEXT(a_count_down, clock, reset, pop && !push, count_ff == $past(count_ff) - CW'(1), "queue count did not shrink")

endmodule

// ===== rtl/core/jsu_back.sv =====
// back end: unless stalled, walks the head bundle one result per cycle into the
// output register; uses jsu_pkg and the assertion macro header
module jsu_back (
   input  logic                clock,
   input  logic                reset,
   input  jsu_pkg::bundle_type head,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // out_byte
   output logic                rsp_tlast,
   output logic [4:0]          rsp_tuser    // byte_valid, string_done, error_code[2:0]
);
   import jsu_pkg::*;
   `include "json_string_unescape_utf8_defines.svh"

   logic       valid_ff;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] byte_ff, byte_in;
   logic       bv_ff, bv_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic [2:0] err_ff, err_in;

   logic [2:0] total;
   logic       load;
   logic       take;

   assign total = head.nbytes + {2'b00, head.status};
   assign load = !valid_ff || rsp_tready;
   assign take = load && !q_empty;

   always_comb begin
      if ({1'b0, idx_ff} < head.nbytes) begin
         byte_in = head.bytes[idx_ff];
         bv_in = 1'b1;
         done_in = 1'b0;
         err_in = ERR_NONE;
         last_in = ({1'b0, idx_ff} + 3'd1 == total);
      end else begin
         byte_in = '0;
         bv_in = 1'b0;
         done_in = head.done;
         err_in = head.err;
         last_in = 1'b1;
      end
      idx_in = idx_ff;
      if (take) begin
         idx_in = last_in ? '0 : idx_ff + 2'd1;
      end
   end

   assign q_pop = take && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            valid_ff <= !q_empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= byte_in;
         bv_ff <= bv_in;
         last_ff <= last_in;
         done_ff <= done_in;
         err_ff <= err_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = byte_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tuser = {err_ff, done_ff, bv_ff};

   `JSU_ASSERT_IMPLY(a_pop_on_last, clock, reset, q_pop, take && last_in, "bundle popped before its last result")
   `JSU_ASSERT_IMPLY(a_idx_in_range, clock, reset, !q_empty, {1'b0, idx_ff} < total, "result index past end of bundle")
   `JSU_ASSERT_IMPLY(a_status_is_last, clock, reset, valid_ff && !bv_ff, last_ff, "status result not marked last")

endmodule

// ===== rtl/core/json_string_unescape_utf8.sv =====
// JSON string body decoder with UTF-8 output.
// Input channel req_*: one raw byte of the string body per transaction, starting
// after the opening quote; req_tlast set means the input ended (byte ignored).
// Output channel rsp_*: one decoded UTF-8 byte or one status result per
// transaction; rsp_tlast marks the final result of an input byte, rsp_tuser
// carries byte_valid, string_done and the error code.
// An input byte causes 0 to 4 results. The front end decodes a byte in the
// cycle it is accepted and writes its results as one bundle into a queue of
// QUEUE_DEPTH entries; while the output is not stalled, the back end hands one
// result per cycle from the queue head to the registered output.
// Throughput: one input byte per cycle while bytes yield at most one result and
// the output is not stalled; the output port, one result per cycle, sets the rate
// for multi-byte results. A stalled output fills the queue, and req_tready drops
// only when it is full. Synchronous reset returns to plain-text state with nothing
// pending and empties the queue; there is no clearing pass.
// Uses jsu_front, jsu_fifo, jsu_back and jsu_pkg.
module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tlast,   // input_ended
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast,   // last
   output logic [4:0] rsp_tuser    // byte_valid, string_done, error_code[2:0]
);
   import jsu_pkg::*;

   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_empty;
   bundle_type q_wdata;
   bundle_type q_head;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   jsu_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/json_string_unescape_utf8_tb.sv =====
// self-checking testbench for the json string unescape core with utf-8 output
// drives directed and random string bodies and checks every result transaction
// against an inline decoder; depends on jsu_pkg and json_string_unescape_utf8
module json_string_unescape_utf8_tb;
   import jsu_pkg::*;

   localparam bit [2:0] PH_TEXT = 3'd0;
   localparam bit [2:0] PH_ESC  = 3'd1;
   localparam bit [2:0] PH_HEX1 = 3'd2;
   localparam bit [2:0] PH_HEX4 = 3'd5;
   localparam int RANDOM_ITEMS = 260;
   localparam int CYCLE_LIMIT  = 60000;

   typedef struct {
      bit [7:0] data;
      bit       valid;
      bit       last;
      bit       done;
      bit [2:0] err;
   } utf8_result_type;

   class unescape_scoreboard;
      bit [2:0]        phase;
      bit [15:0]       hex_acc;
      bit [15:0]       pend_unit;
      bit              pend_valid;
      utf8_result_type expected_utf8[$];
      int              errors;

      function void clear_state();
         phase = PH_TEXT;
         hex_acc = 16'h0;
         pend_unit = 16'h0;
         pend_valid = 1'b0;
      endfunction

      function void add(bit [7:0] data, bit valid, bit done, bit [2:0] err);
         utf8_result_type rec;
         rec.data = data;
         rec.valid = valid;
         rec.last = 1'b0;
         rec.done = done;
         rec.err = err;
         expected_utf8.insert(expected_utf8.size(), rec);
      endfunction

      function void fail_with(bit [2:0] err);
         add(8'h00, 1'b0, 1'b0, err);
         clear_state();
      endfunction

      function void emit_unit(bit [15:0] u);
         if (u < 16'h0080) begin
            add(u[7:0], 1'b1, 1'b0, ERR_NONE);
         end else if (u < 16'h0800) begin
            add(8'hC0 | {3'b0, u[10:6]}, 1'b1, 1'b0, ERR_NONE);
            add(8'h80 | {2'b0, u[5:0]}, 1'b1, 1'b0, ERR_NONE);
         end else begin
            add(8'hE0 | {4'b0, u[15:12]}, 1'b1, 1'b0, ERR_NONE);
            add(8'h80 | {2'b0, u[11:6]}, 1'b1, 1'b0, ERR_NONE);
            add(8'h80 | {2'b0, u[5:0]}, 1'b1, 1'b0, ERR_NONE);
         end
      endfunction

      function void flush_pending();
         if (pend_valid)
            emit_unit(pend_unit);
         pend_valid = 1'b0;
         pend_unit = 16'h0;
      endfunction

      function int hex_value(bit [7:0] c);
         if (c >= "0" && c <= "9") return int'(c - "0");
         if (c >= "a" && c <= "f") return int'(c - "a") + 10;
         if (c >= "A" && c <= "F") return int'(c - "A") + 10;
         return -1;
      endfunction

      // notes one accepted input transaction and queues the results it causes
      function void decode_byte(bit [7:0] c, bit ended);
         int              first;
         int              v;
         bit [7:0]        mapped;
         bit              mapped_ok;
         bit [20:0]       s;
         utf8_result_type rec;
         first = expected_utf8.size();
         mapped = 8'h00;
         mapped_ok = 1'b1;
         if (ended) begin
            fail_with(ERR_EARLY);
         end else if (phase == PH_TEXT) begin
            if (c == "\"") begin
               flush_pending();
               add(8'h00, 1'b0, 1'b1, ERR_NONE);
               clear_state();
            end else if (c < 8'h20) begin
               fail_with(ERR_CTRL);
            end else if (c == "\\") begin
               phase = PH_ESC;
            end else begin
               flush_pending();
               add(c, 1'b1, 1'b0, ERR_NONE);
            end
         end else if (phase == PH_ESC) begin
            case (c) inside
               "b": mapped = 8'h08;
               "f": mapped = 8'h0C;
               "n": mapped = 8'h0A;
               "r": mapped = 8'h0D;
               "t": mapped = 8'h09;
               "\"", "\\", "/": mapped = c;
               default: mapped_ok = 1'b0;
            endcase
            if (c == "u") begin
               phase = PH_HEX1;
               hex_acc = 16'h0;
            end else if (!mapped_ok) begin
               fail_with(ERR_ESCAPE);
            end else begin
               flush_pending();
               add(mapped, 1'b1, 1'b0, ERR_NONE);
               phase = PH_TEXT;
            end
         end else begin
            v = hex_value(c);
            if (v < 0) begin
               fail_with(ERR_HEX);
            end else begin
               hex_acc = {hex_acc[11:0], v[3:0]};
               if (phase == PH_HEX4) begin
                  // high surrogate held back, low surrogate now: one 4-byte sequence
                  if (pend_valid && pend_unit >= 16'hD800 && pend_unit <= 16'hDBFF &&
                      hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                     s = {1'b0, pend_unit[9:0], hex_acc[9:0]} + 21'h10000;
                     add(8'hF0 | {5'b0, s[20:18]}, 1'b1, 1'b0, ERR_NONE);
                     add(8'h80 | {2'b0, s[17:12]}, 1'b1, 1'b0, ERR_NONE);
                     add(8'h80 | {2'b0, s[11:6]}, 1'b1, 1'b0, ERR_NONE);
                     add(8'h80 | {2'b0, s[5:0]}, 1'b1, 1'b0, ERR_NONE);
                     pend_valid = 1'b0;
                     pend_unit = 16'h0;
                  end else begin
                     flush_pending();
                     pend_unit = hex_acc;
                     pend_valid = 1'b1;
                  end
                  phase = PH_TEXT;
                  hex_acc = 16'h0;
               end else begin
                  phase = phase + 3'd1;
               end
            end
         end
         if (expected_utf8.size() > first) begin
            rec = expected_utf8[expected_utf8.size() - 1];
            rec.last = 1'b1;
            expected_utf8[expected_utf8.size() - 1] = rec;
         end
      endfunction

      function void compare_field(string name, int expected_val, int actual);
         if (expected_val != actual) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, expected_val, actual);
            errors++;
         end
      endfunction

      function void check_result(bit [7:0] data, bit last, bit [4:0] user);
         utf8_result_type exp_r;
         if (expected_utf8.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %02h/%0b/%02h",
                     $time, data, last, user);
            errors++;
            return;
         end
         exp_r = expected_utf8.pop_front();
         compare_field("out_byte", exp_r.data, data);
         compare_field("byte_valid", exp_r.valid, user[0]);
         compare_field("string_done", exp_r.done, user[1]);
         compare_field("error_code", exp_r.err, user[4:2]);
         compare_field("last", exp_r.last, last);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // data_byte
   logic       req_tlast = 1'b0;    // input_ended
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // out_byte
   logic       rsp_tlast;           // last
   logic [4:0] rsp_tuser;           // byte_valid, string_done, error_code[2:0]

   unescape_scoreboard board = new();
   int sent_items = 0;
   int cycle_count = 0;
   bit no_gaps = 1'b0;

   json_string_unescape_utf8 uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(99) >= 31);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("json_string_unescape_utf8 regression: fail");
         $finish;
      end
   end

   // valid is only lowered when an idle cycle follows, never between two transactions
   task automatic send_item(input bit [7:0] value, input bit ended);
      while (!no_gaps && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= ended;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.decode_byte(value, ended);
      sent_items++;
   endtask

   function automatic bit [7:0] hex_char(bit [3:0] n);
      if (n < 4'd10)
         return "0" + {4'b0, n};
      return ($urandom_range(1) ? "a" : "A") + {4'b0, n} - 8'd10;
   endfunction

   task automatic send_unit(input bit [15:0] u);
      send_item("\\", 1'b0);
      send_item("u", 1'b0);
      send_item(hex_char(u[15:12]), 1'b0);
      send_item(hex_char(u[11:8]), 1'b0);
      send_item(hex_char(u[7:4]), 1'b0);
      send_item(hex_char(u[3:0]), 1'b0);
   endtask

   task automatic send_bad_input();
      bit [7:0] b;
      int       digits;
      case ($urandom_range(3))
         0: send_item(8'($urandom_range(8'h1F)), 1'b0);
         1: begin
            do b = 8'($urandom_range(255));
            while (b inside {"b", "f", "n", "r", "t", "\"", "\\", "/", "u"});
            send_item("\\", 1'b0);
            send_item(b, 1'b0);
         end
         2: begin
            do b = 8'($urandom_range(255));
            while (board.hex_value(b) >= 0);
            send_item("\\", 1'b0);
            send_item("u", 1'b0);
            digits = $urandom_range(3);
            repeat (digits) send_item(hex_char(4'($urandom_range(15))), 1'b0);
            send_item(b, 1'b0);
         end
         default: begin
            // input ends in plain text, after a backslash or inside a hex escape
            digits = $urandom_range(5);
            if (digits >= 1) send_item("\\", 1'b0);
            if (digits >= 2) send_item("u", 1'b0);
            repeat (digits > 2 ? digits - 2 : 0)
               send_item(hex_char(4'($urandom_range(15))), 1'b0);
            send_item(8'($urandom_range(255)), 1'b1);
         end
      endcase
   endtask

   task automatic send_random_string();
      bit [7:0]  b;
      bit [15:0] u;
      int        pick;
      repeat ($urandom_range(1, 8)) begin
         pick = $urandom_range(99);
         no_gaps = (sent_items >= 130 && sent_items < 200);
         if (pick < 40) begin
            do b = 8'($urandom_range(8'h20, 8'hFF));
            while (b == "\"" || b == "\\");
            send_item(b, 1'b0);
         end else if (pick < 55) begin
            case ($urandom_range(7))
               0: b = "b";
               1: b = "f";
               2: b = "n";
               3: b = "r";
               4: b = "t";
               5: b = "\"";
               6: b = "\\";
               default: b = "/";
            endcase
            send_item("\\", 1'b0);
            send_item(b, 1'b0);
         end else if (pick < 80) begin
            case ($urandom_range(3))
               0: u = 16'($urandom_range(16'h007F));
               1: u = 16'($urandom_range(16'h0080, 16'h07FF));
               2: u = 16'($urandom_range(16'h0800, 16'hFFFF));
               default: u = 16'($urandom_range(16'hD800, 16'hDFFF));
            endcase
            send_unit(u);
         end else if (pick < 92) begin
            send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
            send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
         end else begin
            send_bad_input();
            return;
         end
      end
      if ($urandom_range(9) != 0)
         send_item("\"", 1'b0);
      else
         send_item(8'($urandom_range(255)), 1'b1);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain bytes at both ends, a simple escape, a 2-byte unit held back,
      // then a surrogate pair that flushes it, and the closing quote
      send_item(8'h20, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item("\\", 1'b0);
      send_item("t", 1'b0);
      send_item("\\", 1'b0);
      send_item("u", 1'b0);
      send_item("0", 1'b0);
      send_item("7", 1'b0);
      send_item("f", 1'b0);
      send_item("F", 1'b0);
      send_unit(16'hD83D);
      send_unit(16'hDE00);
      send_item("\"", 1'b0);
      // each error kind
      send_item(8'h1F, 1'b0);
      send_item("\\", 1'b0);
      send_item("q", 1'b0);
      send_item("\\", 1'b0);
      send_item("u", 1'b0);
      send_item("g", 1'b0);
      send_item(8'h00, 1'b1);

      while (sent_items < RANDOM_ITEMS)
         send_random_string();
      no_gaps = 1'b0;
      req_tvalid <= 1'b0;

      while (board.expected_utf8.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (board.errors == 0 && board.expected_utf8.size() == 0)
         $display("json_string_unescape_utf8 regression: pass");
      else
         $display("json_string_unescape_utf8 regression: fail");
      $finish;
   end
endmodule
